FILE: rtl/core/kswa_pkg.sv
// Shared types and constants for the keyed sample window averager.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package kswa_pkg;

  localparam int DATA_W = 16;

  typedef enum logic [0:0] {
    ACT_STORE  = 1'b0,
    ACT_REPORT = 1'b1
  } action_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOOK  = 9'b000000010,
    S_WRITE = 9'b000000100,
    S_RKEY  = 9'b000001000,
    S_SUM   = 9'b000010000,
    S_DGO   = 9'b000100000,
    S_DWAIT = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/kswa_store.sv
// Key/fill memory and sample memory, one write and one registered read port each.
// Depends on kswa_pkg for the sample field width.
module kswa_store #(
  parameter int EW  = 4,
  parameter int NE  = 10,
  parameter int CW  = 3,
  parameter int SAW = 6,
  parameter int NS  = 60
) (
  input  logic                            clk,
  input  logic [EW-1:0]                   kr_addr,
  output logic [kswa_pkg::DATA_W-1:0]     kr_key,
  output logic [CW-1:0]                   kr_fill,
  input  logic                            kw_en,
  input  logic [EW-1:0]                   kw_addr,
  input  logic [kswa_pkg::DATA_W-1:0]     kw_key,
  input  logic [CW-1:0]                   kw_fill,
  input  logic [SAW-1:0]                  sr_addr,
  output logic [2*kswa_pkg::DATA_W-1:0]   sr_data,
  input  logic                            sw_en,
  input  logic [SAW-1:0]                  sw_addr,
  input  logic [2*kswa_pkg::DATA_W-1:0]   sw_data
);

  localparam int KW = kswa_pkg::DATA_W + CW;

  logic [KW-1:0]                 key_mem [NE];
  logic [2*kswa_pkg::DATA_W-1:0] smp_mem [NS];
  logic [KW-1:0]                 krd_r;
  logic [2*kswa_pkg::DATA_W-1:0] srd_r;

  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[kw_addr] <= {kw_key, kw_fill};
    end
    krd_r <= key_mem[kr_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      smp_mem[sw_addr] <= sw_data;
    end
    srd_r <= smp_mem[sr_addr];
  end

  assign kr_key  = krd_r[KW-1:CW];
  assign kr_fill = krd_r[CW-1:0];
  assign sr_data = srd_r;

endmodule

FILE: rtl/core/kswa_div.sv
// Two-lane restoring divider sharing one divisor, one quotient bit per cycle.
// Depends on kswa_pkg for the status struct.
module kswa_div #(
  parameter int SW = 19,
  parameter int CW = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SW-1:0]       dvd_a,
  input  logic [SW-1:0]       dvd_b,
  input  logic [CW-1:0]       dvs,
  output logic [SW-1:0]       quo_a,
  output logic [SW-1:0]       quo_b,
  output kswa_pkg::div_stat_t stat
);

  localparam int STW = $clog2(SW + 1);
  localparam logic [STW-1:0] LAST_STEP = STW'(SW - 1);

  logic           busy_r, done_r;
  logic [STW-1:0] step_r;
  logic [SW-1:0]  qa_r, qb_r, qa_nxt, qb_nxt;
  logic [CW-1:0]  ra_r, rb_r, ra_nxt, rb_nxt;
  logic [CW-1:0]  dvs_r;
  logic [CW:0]    sha, shb;

  always_comb begin
    sha = {ra_r, qa_r[SW-1]};
    shb = {rb_r, qb_r[SW-1]};
    if (sha >= {1'b0, dvs_r}) begin
      ra_nxt = CW'(sha - {1'b0, dvs_r});
      qa_nxt = {qa_r[SW-2:0], 1'b1};
    end else begin
      ra_nxt = sha[CW-1:0];
      qa_nxt = {qa_r[SW-2:0], 1'b0};
    end
    if (shb >= {1'b0, dvs_r}) begin
      rb_nxt = CW'(shb - {1'b0, dvs_r});
      qb_nxt = {qb_r[SW-2:0], 1'b1};
    end else begin
      rb_nxt = shb[CW-1:0];
      qb_nxt = {qb_r[SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qa_r  <= dvd_a;
      qb_r  <= dvd_b;
      ra_r  <= '0;
      rb_r  <= '0;
      dvs_r <= dvs;
    end else if (busy_r) begin
      qa_r <= qa_nxt;
      qb_r <= qb_nxt;
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
    end
  end

  assign quo_a     = qa_r;
  assign quo_b     = qb_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/core/keyed_sample_window_averager_unit.sv
// Top level: sensor table walk, sample write-back and report sequencer.
// Depends on kswa_pkg, kswa_store and kswa_div.
//
//   channel | direction | ports
//   in_     | input     | in_valid, in_stall, in_action, in_node_address, in_temperature,
//           |           | in_light_level
//   out_    | output    | out_valid, out_stall, out_sensor_address, out_average_temperature,
//           |           | out_average_light, out_last_sensor
//
// Store word: walks k table entries (at most MAX_ENTRIES), one key read each; a full table
//   drops a word whose key is new.
// Report word: per sensor, a key read, a sample memory read of one slot per cycle over its
//   fill, then the serial divider.
// Input accepted only between words; one output register holds a finished line.
// Reset clears the sensor count and control only; memories are not swept.
// out_stall holds the report at its next line; the table is untouched meanwhile.
module keyed_sample_window_averager_unit #(
  parameter int MAX_ENTRIES  = 10,
  parameter int WINDOW_DEPTH = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_node_address,
  input  logic [15:0] in_temperature,
  input  logic [15:0] in_light_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_sensor_address,
  output logic [15:0] out_average_temperature,
  output logic [15:0] out_average_light,
  output logic        out_last_sensor
);

  localparam int DW  = kswa_pkg::DATA_W;
  localparam int EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NCW = $clog2(MAX_ENTRIES + 1);
  localparam int CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SLW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int NS  = MAX_ENTRIES * WINDOW_DEPTH;
  localparam int SAW = (NS > 1) ? $clog2(NS) : 1;
  localparam int SW  = DW + CW;
  localparam logic [NCW-1:0] N_FULL = NCW'(MAX_ENTRIES);
  localparam logic [CW-1:0]  W_C    = CW'(WINDOW_DEPTH);
  localparam logic [SAW-1:0] W_A    = SAW'(WINDOW_DEPTH);

  kswa_pkg::state_t state_r, state_nxt;
  logic [NCW-1:0] count_r, count_nxt;
  logic [EW-1:0]  ent_r, ent_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [SLW-1:0] slot_r, slot_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [DW-1:0]  addr_r, addr_nxt, temp_r, temp_nxt, light_r, light_nxt;
  logic [DW-1:0]  key_r, key_nxt;
  logic [SW-1:0]  tsum_r, tsum_nxt, lsum_r, lsum_nxt;
  logic           out_valid_r, out_valid_nxt, last_r, last_nxt;
  logic [DW-1:0]  oaddr_r, oaddr_nxt, otemp_r, otemp_nxt, olight_r, olight_nxt;

  logic [EW-1:0]         kr_addr;
  logic [DW-1:0]         kr_key;
  logic [CW-1:0]         kr_fill;
  logic                  kw_en;
  logic [CW-1:0]         kw_fill;
  logic [SAW-1:0]        samp_base, sr_addr, sw_addr;
  logic [2*DW-1:0]       sr_data;
  logic                  sw_en;
  logic [SLW-1:0]        wr_slot;
  logic                  div_start;
  logic [SW-1:0]         quo_t, quo_l;
  kswa_pkg::div_stat_t   div_stat;
  logic                  in_acc, out_free, is_last;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign is_last   = (NCW'(ent_r) + 1'b1) == count_r;
  assign samp_base = SAW'(ent_r) * W_A;
  assign wr_slot   = (fill_r >= W_C) ? '0 : SLW'(fill_r);
  assign kw_fill   = CW'(wr_slot) + 1'b1;
  assign kw_en     = (state_r == kswa_pkg::S_WRITE);
  assign sw_en     = kw_en;
  assign sw_addr   = samp_base + SAW'(wr_slot);
  assign sr_addr   = samp_base + SAW'(slot_nxt);
  assign div_start = (state_r == kswa_pkg::S_DGO);
  assign in_stall  = (state_r != kswa_pkg::S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ent_nxt       = ent_r;
    fill_nxt      = fill_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    temp_nxt      = temp_r;
    light_nxt     = light_r;
    key_nxt       = key_r;
    tsum_nxt      = tsum_r;
    lsum_nxt      = lsum_r;
    kr_addr       = ent_r;
    out_valid_nxt = out_valid_r && out_stall;
    last_nxt      = last_r;
    oaddr_nxt     = oaddr_r;
    otemp_nxt     = otemp_r;
    olight_nxt    = olight_r;
    unique case (state_r)
      kswa_pkg::S_IDLE: begin
        kr_addr = '0;
        if (in_acc) begin
          addr_nxt  = in_node_address;
          temp_nxt  = in_temperature;
          light_nxt = in_light_level;
          ent_nxt   = '0;
          if (in_action == kswa_pkg::ACT_REPORT) begin
            if (count_r != '0) begin
              state_nxt = kswa_pkg::S_RKEY;
            end
          end else if (count_r == '0) begin
            fill_nxt  = '0;
            count_nxt = count_r + 1'b1;
            state_nxt = kswa_pkg::S_WRITE;
          end else begin
            state_nxt = kswa_pkg::S_LOOK;
          end
        end
      end
      kswa_pkg::S_LOOK: begin
        kr_addr = ent_r + 1'b1;
        if (kr_key == addr_r) begin
          fill_nxt  = kr_fill;
          state_nxt = kswa_pkg::S_WRITE;
        end else if (is_last) begin
          if (count_r == N_FULL) begin
            state_nxt = kswa_pkg::S_IDLE;
          end else begin
            ent_nxt   = EW'(count_r);
            fill_nxt  = '0;
            count_nxt = count_r + 1'b1;
            state_nxt = kswa_pkg::S_WRITE;
          end
        end else begin
          ent_nxt = ent_r + 1'b1;
        end
      end
      kswa_pkg::S_WRITE: begin
        state_nxt = kswa_pkg::S_IDLE;
      end
      kswa_pkg::S_RKEY: begin
        key_nxt  = kr_key;
        cnt_nxt  = (kr_fill > W_C) ? W_C : kr_fill;
        tsum_nxt = '0;
        lsum_nxt = '0;
        slot_nxt = '0;
        if (kr_fill == '0) begin
          state_nxt = kswa_pkg::S_DGO;
        end else begin
          state_nxt = kswa_pkg::S_SUM;
        end
      end
      kswa_pkg::S_SUM: begin
        tsum_nxt = tsum_r + SW'(sr_data[DW-1:0]);
        lsum_nxt = lsum_r + SW'(sr_data[2*DW-1:DW]);
        if ((CW'(slot_r) + 1'b1) == cnt_r) begin
          state_nxt = kswa_pkg::S_DGO;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      kswa_pkg::S_DGO: begin
        state_nxt = kswa_pkg::S_DWAIT;
      end
      kswa_pkg::S_DWAIT: begin
        if (div_stat.done) begin
          state_nxt = kswa_pkg::S_EMIT;
        end
      end
      kswa_pkg::S_EMIT: begin
        kr_addr = ent_r + 1'b1;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          oaddr_nxt     = key_r;
          otemp_nxt     = (cnt_r == '0) ? '0 : quo_t[DW-1:0];
          olight_nxt    = (cnt_r == '0) ? '0 : quo_l[DW-1:0];
          last_nxt      = is_last;
          if (is_last) begin
            state_nxt = kswa_pkg::S_IDLE;
          end else begin
            ent_nxt   = ent_r + 1'b1;
            state_nxt = kswa_pkg::S_RKEY;
          end
        end
      end
      default: begin
        state_nxt = kswa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kswa_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r    <= ent_nxt;
    fill_r   <= fill_nxt;
    slot_r   <= slot_nxt;
    cnt_r    <= cnt_nxt;
    addr_r   <= addr_nxt;
    temp_r   <= temp_nxt;
    light_r  <= light_nxt;
    key_r    <= key_nxt;
    tsum_r   <= tsum_nxt;
    lsum_r   <= lsum_nxt;
    last_r   <= last_nxt;
    oaddr_r  <= oaddr_nxt;
    otemp_r  <= otemp_nxt;
    olight_r <= olight_nxt;
  end

  kswa_store #(
    .EW  (EW),
    .NE  (MAX_ENTRIES),
    .CW  (CW),
    .SAW (SAW),
    .NS  (NS)
  ) u_store (
    .clk     (clk),
    .kr_addr (kr_addr),
    .kr_key  (kr_key),
    .kr_fill (kr_fill),
    .kw_en   (kw_en),
    .kw_addr (ent_r),
    .kw_key  (addr_r),
    .kw_fill (kw_fill),
    .sr_addr (sr_addr),
    .sr_data (sr_data),
    .sw_en   (sw_en),
    .sw_addr (sw_addr),
    .sw_data ({light_r, temp_r})
  );

  kswa_div #(
    .SW (SW),
    .CW (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd_a (tsum_r),
    .dvd_b (lsum_r),
    .dvs   (cnt_r),
    .quo_a (quo_t),
    .quo_b (quo_l),
    .stat  (div_stat)
  );

  assign out_valid               = out_valid_r;
  assign out_sensor_address      = oaddr_r;
  assign out_average_temperature = otemp_r;
  assign out_average_light       = olight_r;
  assign out_last_sensor         = last_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= N_FULL)
    else $error("sensor count beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && count_r != $past(count_r)) |-> count_r == $past(count_r) + 1'b1)
    else $error("sensor count moved by other than one");

  a_emit_only: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == kswa_pkg::S_EMIT))
    else $error("result word raised outside report emit");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kswa_pkg::S_EMIT && out_free && is_last) |=> state_r == kswa_pkg::S_IDLE)
    else $error("report did not end on its last line");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for keyed_sample_window_averager_unit.
// Runs a directed table of words and then random words against a behavioral model of the
// sensor table; depends on kswa_pkg and the RTL under rtl/core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SENSORS      = 10;
  localparam int WINDOW       = 6;
  localparam int RANDOM_WORDS = 435;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 400;
  localparam int DIR_ROWS     = 25;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_LINES,
    ROW_ONE_LINE
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    kswa_pkg::action_t act;
    logic [15:0]       addr;
    logic [15:0]       temp;
    logic [15:0]       light;
    logic [15:0]       e_addr;
    logic [15:0]       e_temp;
    logic [15:0]       e_light;
    logic              e_last;
  } dir_row_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] temp;
    logic [15:0] light;
    logic        last;
  } report_line_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = kswa_pkg::ACT_STORE;
  logic [15:0] in_node_address = 16'h0000;
  logic [15:0] in_temperature = 16'h0000;
  logic [15:0] in_light_level = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_sensor_address;
  logic [15:0] out_average_temperature;
  logic [15:0] out_average_light;
  logic        out_last_sensor;

  logic [15:0] model_key   [SENSORS];
  logic [2:0]  model_fill  [SENSORS];
  logic [15:0] model_temp  [SENSORS][WINDOW];
  logic [15:0] model_light [SENSORS][WINDOW];
  int          model_used = 0;

  report_line_t report_lines_q [$];
  int           errors = 0;
  int           idle_cycles = 0;
  int           gapless_left = 0;
  int           stall_left = 0;
  int           stall_pick;
  logic         stall_hold = 1'b0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_NO_LINES, kswa_pkg::ACT_REPORT, 16'h0000, 16'h0000, 16'h0000,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h0000, 16'hFFFF, 16'h0000,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_ONE_LINE, kswa_pkg::ACT_REPORT, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'hFFFF, 16'h0000, 1'b1},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h0000, 16'h0001, 16'hFFFF,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_ONE_LINE, kswa_pkg::ACT_REPORT, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h8000, 16'h7FFF, 1'b1},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h0000, 16'hFFFF, 16'hFFFF,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h0000, 16'hFFFF, 16'hFFFF,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h0000, 16'hFFFF, 16'hFFFF,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h0000, 16'hFFFF, 16'hFFFF,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_REPORT, 16'h0000, 16'h0000, 16'h0000,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h0000, 16'h1234, 16'hABCD,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_ONE_LINE, kswa_pkg::ACT_REPORT, 16'h0000, 16'h0000, 16'h0000,
      16'h0000, 16'h1234, 16'hABCD, 1'b1},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'hFFFF, 16'h0000, 16'hFFFF,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_REPORT, 16'h5A5A, 16'hC3C3, 16'h3C3C,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h0001, 16'h0000, 16'h0000,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h8000, 16'hFFFF, 16'hFFFF,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h5555, 16'hAAAA, 16'h5555,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'hAAAA, 16'h5555, 16'hAAAA,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h00FF, 16'h00FF, 16'hFF00,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'hFF00, 16'hFF00, 16'h00FF,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h1234, 16'h0102, 16'h0304,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'hFEDC, 16'h7FFF, 16'h8000,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h7FFF, 16'h1111, 16'h2222,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_STORE,  16'h0000, 16'h0000, 16'h0000,
      16'h0, 16'h0, 16'h0, 1'b0},
    '{ROW_PREDICT,  kswa_pkg::ACT_REPORT, 16'h0000, 16'h0000, 16'h0000,
      16'h0, 16'h0, 16'h0, 1'b0}
  };

  keyed_sample_window_averager_unit #(
    .MAX_ENTRIES (SENSORS),
    .WINDOW_DEPTH(WINDOW)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_action              (in_action),
    .in_node_address        (in_node_address),
    .in_temperature         (in_temperature),
    .in_light_level         (in_light_level),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_sensor_address     (out_sensor_address),
    .out_average_temperature(out_average_temperature),
    .out_average_light      (out_average_light),
    .out_last_sensor        (out_last_sensor)
  );

  always #6 clk = ~clk;

  // Returns 1 unless the word is a sample dropped by a full table.
  function automatic bit sensor_table_apply(kswa_pkg::action_t act, logic [15:0] addr,
                                            logic [15:0] temp, logic [15:0] light,
                                            bit keep_lines);
    int           e;
    int           slot;
    logic [18:0]  t_sum;
    logic [18:0]  l_sum;
    report_line_t line;
    if (act == kswa_pkg::ACT_REPORT) begin
      for (e = 0; e < model_used; e++) begin
        t_sum = '0;
        l_sum = '0;
        for (slot = 0; slot < model_fill[e]; slot++) begin
          t_sum += model_temp[e][slot];
          l_sum += model_light[e][slot];
        end
        line.addr  = model_key[e];
        line.temp  = (model_fill[e] == 0) ? 16'h0000 : 16'(t_sum / model_fill[e]);
        line.light = (model_fill[e] == 0) ? 16'h0000 : 16'(l_sum / model_fill[e]);
        line.last  = (e == model_used - 1);
        if (keep_lines) report_lines_q.push_back(line);
      end
      return 1'b1;
    end
    for (e = 0; e < model_used; e++) begin
      if (model_key[e] == addr) break;
    end
    if (e == model_used) begin
      if (model_used == SENSORS) return 1'b0;
      model_key[e]  = addr;
      model_fill[e] = '0;
      model_used++;
    end
    slot = (model_fill[e] == WINDOW) ? 0 : model_fill[e];
    model_temp[e][slot]  = temp;
    model_light[e][slot] = light;
    model_fill[e]        = 3'(slot + 1);
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int pick;
    if (gapless_left > 0) begin
      gapless_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      gapless_left = $urandom_range(5, 20);
      return 0;
    end
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_reading();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 16'h0000;
    if (pick < 16) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send_word(kswa_pkg::action_t act, logic [15:0] addr, logic [15:0] temp,
                           logic [15:0] light);
    int gap;
    bit took;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_node_address <= addr;
    in_temperature  <= temp;
    in_light_level  <= light;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic check_line();
    report_line_t want;
    if (report_lines_q.size() == 0) begin
      $display("%0t: unexpected line addr=%h temp=%h light=%h last=%b", $time,
               out_sensor_address, out_average_temperature, out_average_light,
               out_last_sensor);
      errors++;
      return;
    end
    want = report_lines_q.pop_front();
    if (out_sensor_address !== want.addr) begin
      $display("%0t: sensor_address expected %h actual %h", $time, want.addr,
               out_sensor_address);
      errors++;
    end
    if (out_average_temperature !== want.temp) begin
      $display("%0t: average_temperature expected %h actual %h", $time, want.temp,
               out_average_temperature);
      errors++;
    end
    if (out_average_light !== want.light) begin
      $display("%0t: average_light expected %h actual %h", $time, want.light,
               out_average_light);
      errors++;
    end
    if (out_last_sensor !== want.last) begin
      $display("%0t: last_sensor expected %b actual %b", $time, want.last,
               out_last_sensor);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 40) begin
        stall_hold = 1'b0;
        stall_left = $urandom_range(1, 30);
      end else if (stall_pick < 90) begin
        stall_hold = 1'b1;
        stall_left = $urandom_range(1, 4);
      end else begin
        stall_hold = 1'b1;
        stall_left = $urandom_range(20, 80);
      end
    end
    out_stall <= stall_hold;
    stall_left--;
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_line();
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int                i;
    int                taken;
    int                pick;
    kswa_pkg::action_t act;
    logic [15:0]       addr;
    report_line_t      line;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < DIR_ROWS; i++) begin
      send_word(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].temp, dir_rows[i].light);
      void'(sensor_table_apply(dir_rows[i].act, dir_rows[i].addr, dir_rows[i].temp,
                               dir_rows[i].light, dir_rows[i].kind == ROW_PREDICT));
      if (dir_rows[i].kind == ROW_ONE_LINE) begin
        line = '{dir_rows[i].e_addr, dir_rows[i].e_temp, dir_rows[i].e_light,
                 dir_rows[i].e_last};
        report_lines_q.push_back(line);
      end
    end
    taken = 0;
    while (taken < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        act  = kswa_pkg::ACT_REPORT;
        addr = 16'($urandom);
      end else if (pick < 88) begin
        act  = kswa_pkg::ACT_STORE;
        addr = model_key[$urandom_range(0, model_used - 1)];
      end else begin
        act  = kswa_pkg::ACT_STORE;
        addr = 16'($urandom);
      end
      send_word(act, addr, pick_reading(), pick_reading());
      void'(sensor_table_apply(act, addr, in_temperature, in_light_level, 1'b1));
      taken++;
    end
    in_valid <= 1'b0;
    while (report_lines_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
